FILE: sv/lfps_pkg.sv
`default_nettype none

package lfps_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 56;
    localparam int POS_W    = 10;
    localparam int SIZE_W   = 11;
    localparam int COEFF_W  = 20;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 2;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int MIN_SIZE     = 3;

    localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1024;
    localparam logic [COEFF_W-1:0] COEFF_RST = 20'd1046529;

    typedef enum logic [IDX_W-1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_COEFFV = 2'd2,
        REG_COEFFH = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/laplacian_five_point_stencil.sv
// Five-point Laplacian stencil over a row-major grid stream.
// An accepted sample passes stage A, stage B and the output register before its result shows.
// Throughput: one sample per cycle unless held by result_ready; one store write, two reads.
// Reset: row and column counters clear, the size and coefficient registers take their
// defaults; the line store is not cleared, unwritten entries feed no result.
`default_nettype none

module laplacian_five_point_stencil #(
    parameter int MAX_COLS = lfps_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lfps_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [lfps_pkg::IDX_W-1:0]            cfg_index,
    input  wire logic [lfps_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  sample_valid,
    output logic                                       sample_ready,
    input  wire logic signed [lfps_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic signed [lfps_pkg::RESULT_W-1:0]       result,
    output logic [lfps_pkg::POS_W-1:0]                 center_row,
    output logic [lfps_pkg::POS_W-1:0]                 center_col,
    output logic                                       last
);

    localparam int SAMPLE_W = lfps_pkg::SAMPLE_W;
    localparam int RESULT_W = lfps_pkg::RESULT_W;
    localparam int POS_W    = lfps_pkg::POS_W;
    localparam int SIZE_W   = lfps_pkg::SIZE_W;
    localparam int COEFF_W  = lfps_pkg::COEFF_W;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DEPTH    = 2 * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PROD_W   = SAMPLE_W + COEFF_W + 2;

    // configuration
    logic [SIZE_W-1:0]  rows_in_use_reg;
    logic [SIZE_W-1:0]  cols_in_use_reg;
    logic [COEFF_W-1:0] coeff_vertical_reg;
    logic [COEFF_W-1:0] coeff_horizontal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg      <= lfps_pkg::SIZE_RST;
            cols_in_use_reg      <= lfps_pkg::SIZE_RST;
            coeff_vertical_reg   <= lfps_pkg::COEFF_RST;
            coeff_horizontal_reg <= lfps_pkg::COEFF_RST;
        end
        else if (cfg_we)
        begin
            unique case (lfps_pkg::cfg_reg_t'(cfg_index))
                lfps_pkg::REG_ROWS:   rows_in_use_reg      <= cfg_data[SIZE_W-1:0];
                lfps_pkg::REG_COLS:   cols_in_use_reg      <= cfg_data[SIZE_W-1:0];
                lfps_pkg::REG_COEFFV: coeff_vertical_reg   <= cfg_data[COEFF_W-1:0];
                lfps_pkg::REG_COEFFH: coeff_horizontal_reg <= cfg_data[COEFF_W-1:0];
                default:              coeff_horizontal_reg <= coeff_horizontal_reg;
            endcase
        end
    end

    // clamp grid size into range, keep last index
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;

    always_comb
    begin
        priority if (rows_in_use_reg < SIZE_W'(lfps_pkg::MIN_SIZE))
            last_row = ROW_W'(lfps_pkg::MIN_SIZE - 1);
        else if (32'(rows_in_use_reg) > 32'(MAX_ROWS))
            last_row = ROW_W'(MAX_ROWS - 1);
        else
            last_row = ROW_W'(rows_in_use_reg - SIZE_W'(1));

        priority if (cols_in_use_reg < SIZE_W'(lfps_pkg::MIN_SIZE))
            last_col = COL_W'(lfps_pkg::MIN_SIZE - 1);
        else if (32'(cols_in_use_reg) > 32'(MAX_COLS))
            last_col = COL_W'(MAX_COLS - 1);
        else
            last_col = COL_W'(cols_in_use_reg - SIZE_W'(1));
    end

    // pipeline control
    logic a_valid_reg;
    logic b_valid_reg;
    logic result_valid_reg;
    logic out_en;
    logic b_en;
    logic a_en;
    logic accept;
    logic a_move;

    assign out_en       = !result_valid_reg || result_ready;
    assign b_en         = !b_valid_reg || out_en;
    assign a_en         = !a_valid_reg || b_en;
    assign sample_ready = a_en;
    assign accept       = sample_valid && a_en;
    assign a_move       = a_valid_reg && b_en;

    // grid position
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic             interior;
    logic             at_last;
    logic [COL_W-1:0] east_col;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] north_addr;
    logic [ADDR_W-1:0] east_addr;

    always_comb
    begin
        interior = (row_count_reg >= ROW_W'(2)) && (row_count_reg <= last_row)
                   && (col_count_reg != '0) && (col_count_reg < last_col);
        at_last  = (row_count_reg == last_row) && (col_count_reg == last_col - COL_W'(1));

        if (col_count_reg >= last_col)
        begin
            col_count_next = '0;
            row_count_next = (row_count_reg >= last_row) ? '0 : row_count_reg + ROW_W'(1);
        end
        else
        begin
            col_count_next = col_count_reg + COL_W'(1);
            row_count_next = row_count_reg;
        end

        east_col = (col_count_reg == COL_W'(MAX_COLS - 1)) ? '0 : col_count_reg + COL_W'(1);

        // row r lives in half r[0]; row r-1 in the other half
        wr_addr   = (row_count_reg[0] ? ADDR_W'(MAX_COLS) : '0) + ADDR_W'(col_count_reg);
        east_addr = (row_count_reg[0] ? '0 : ADDR_W'(MAX_COLS)) + ADDR_W'(east_col);
        // column 0 fetches the west point of the row above instead of north
        if (col_count_reg == '0)
            north_addr = row_count_reg[0] ? '0 : ADDR_W'(MAX_COLS);
        else
            north_addr = wr_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // line store: two rows, read before write
    logic signed [SAMPLE_W-1:0] row_store [DEPTH];
    logic signed [SAMPLE_W-1:0] north_rd_reg;
    logic signed [SAMPLE_W-1:0] east_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            north_rd_reg       <= row_store[north_addr];
            east_rd_reg        <= row_store[east_addr];
            row_store[wr_addr] <= sample;
        end
    end

    // stage A: accepted sample
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    logic                       a_interior_reg;
    logic                       a_first_reg;
    logic                       a_last_reg;
    logic [ROW_W-1:0]           a_row_reg;
    logic [COL_W-1:0]           a_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_en)
            a_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg   <= sample;
            a_interior_reg <= interior;
            a_first_reg    <= (col_count_reg == '0);
            a_last_reg     <= at_last;
            a_row_reg      <= row_count_reg - ROW_W'(1);
            a_col_reg      <= col_count_reg;
        end
    end

    // window over the row above: west and centre
    logic signed [SAMPLE_W-1:0] centre_reg;
    logic signed [SAMPLE_W-1:0] west_reg;

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            centre_reg <= east_rd_reg;
            west_reg   <= a_first_reg ? north_rd_reg : centre_reg;
        end
    end

    // stage B: products
    logic [COEFF_W:0]            coeff_sum;
    logic signed [SAMPLE_W:0]    vert_sum;
    logic signed [SAMPLE_W:0]    horz_sum;
    logic signed [PROD_W-1:0]    prod_c_reg;
    logic signed [PROD_W-1:0]    prod_v_reg;
    logic signed [PROD_W-1:0]    prod_h_reg;
    logic                        b_last_reg;
    logic [ROW_W-1:0]            b_row_reg;
    logic [COL_W-1:0]            b_col_reg;

    always_comb
    begin
        coeff_sum = {1'b0, coeff_vertical_reg} + {1'b0, coeff_horizontal_reg};
        vert_sum  = {north_rd_reg[SAMPLE_W-1], north_rd_reg}
                    + {a_sample_reg[SAMPLE_W-1], a_sample_reg};
        horz_sum  = {west_reg[SAMPLE_W-1], west_reg} + {east_rd_reg[SAMPLE_W-1], east_rd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_en)
            b_valid_reg <= a_valid_reg && a_interior_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            prod_c_reg <= $signed({1'b0, coeff_sum}) * centre_reg;
            prod_v_reg <= $signed({2'b0, coeff_vertical_reg}) * vert_sum;
            prod_h_reg <= $signed({2'b0, coeff_horizontal_reg}) * horz_sum;
            b_last_reg <= a_last_reg;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
        end
    end

    // output register
    logic signed [RESULT_W-1:0] result_reg;
    logic signed [RESULT_W-1:0] result_next;
    logic [ROW_W-1:0]           out_row_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic                       out_last_reg;

    always_comb
    begin
        result_next = RESULT_W'(prod_v_reg) + RESULT_W'(prod_h_reg)
                      - (RESULT_W'(prod_c_reg) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_en)
            result_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && b_valid_reg)
        begin
            result_reg   <= result_next;
            out_row_reg  <= b_row_reg;
            out_col_reg  <= b_col_reg;
            out_last_reg <= b_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign center_row   = POS_W'(out_row_reg);
    assign center_col   = POS_W'(out_col_reg);
    assign last         = out_last_reg;

    // hold off requests only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> a_valid_reg && b_valid_reg && result_valid_reg && !result_ready)
        else $error("request refused with room in the pipeline");

    a_b_from_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(a_valid_reg) && $past(a_interior_reg))
        else $error("stage B filled without an interior item");

    a_centre_interior: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (out_col_reg != '0) && (out_row_reg != '0))
        else $error("result on a boundary point");

endmodule

`default_nettype wire

FILE: tb/stencil_checker.sv
module stencil_checker
    import lfps_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,
    input  wire logic                       sample_valid,
    input  wire logic                       sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       result_valid,
    input  wire logic                       result_ready,
    input  wire logic signed [RESULT_W-1:0] result,
    input  wire logic [POS_W-1:0]           center_row,
    input  wire logic [POS_W-1:0]           center_col,
    input  wire logic                       last,
    output int                              mismatches,
    output int                              points_due
);

    localparam int NCOLS = MAX_COLS_DEF;

    typedef struct packed {
        logic signed [RESULT_W-1:0] value;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
        logic                       last;
    } stencil_point_t;

    stencil_point_t             pending_points[$];
    logic signed [SAMPLE_W-1:0] line_rows [0:2*NCOLS-1];
    logic [SIZE_W-1:0]          rows_reg;
    logic [SIZE_W-1:0]          cols_reg;
    logic [COEFF_W-1:0]         cv_reg;
    logic [COEFF_W-1:0]         ch_reg;
    int                         next_row;
    int                         next_col;

    function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int hi);
        if (v < MIN_SIZE)
        begin
            return MIN_SIZE;
        end
        if (v > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int             rows;
        int             cols;
        longint         cv;
        longint         ch;
        longint         north;
        longint         centre;
        longint         west;
        longint         east;
        longint         south;
        longint         z;
        stencil_point_t p;
        rows = clamp_dim(rows_reg, MAX_ROWS_DEF);
        cols = clamp_dim(cols_reg, NCOLS);
        if (next_row >= 2 && next_row <= rows - 1 && next_col >= 1 && next_col <= cols - 2)
        begin
            cv = cv_reg;
            ch = ch_reg;
            south = s;
            north = line_rows[(next_row % 2) * NCOLS + next_col];
            centre = line_rows[((next_row - 1) % 2) * NCOLS + next_col];
            west = line_rows[((next_row - 1) % 2) * NCOLS + next_col - 1];
            east = line_rows[((next_row - 1) % 2) * NCOLS + next_col + 1];
            z = -2 * (cv + ch) * centre + cv * (north + south) + ch * (west + east);
            p.value = z[RESULT_W-1:0];
            p.row = POS_W'(next_row - 1);
            p.col = POS_W'(next_col);
            p.last = (next_row == rows - 1 && next_col == cols - 2);
            pending_points.push_back(p);
        end
        line_rows[(next_row % 2) * NCOLS + next_col] = s;
        if (next_col >= cols - 1)
        begin
            next_col = 0;
            next_row = (next_row >= rows - 1) ? 0 : next_row + 1;
        end
        else
        begin
            next_col = next_col + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        stencil_point_t want;
        int             errs;
        if (!rst_n)
        begin
            rows_reg = SIZE_RST;
            cols_reg = SIZE_RST;
            cv_reg = COEFF_RST;
            ch_reg = COEFF_RST;
            next_row = 0;
            next_col = 0;
            pending_points.delete();
            mismatches <= 0;
            points_due <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROWS:   rows_reg = cfg_data[SIZE_W-1:0];
                    REG_COLS:   cols_reg = cfg_data[SIZE_W-1:0];
                    REG_COEFFV: cv_reg = cfg_data[COEFF_W-1:0];
                    REG_COEFFH: ch_reg = cfg_data[COEFF_W-1:0];
                    default:    ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                take_sample(sample);
            end
            if (result_valid && result_ready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("result at row %0d col %0d with no request pending",
                           center_row, center_col);
                    errs++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (result !== want.value)
                    begin
                        $error("result: expected %0d, got %0d", want.value, result);
                        errs++;
                    end
                    if (center_row !== want.row)
                    begin
                        $error("center_row: expected %0d, got %0d", want.row, center_row);
                        errs++;
                    end
                    if (center_col !== want.col)
                    begin
                        $error("center_col: expected %0d, got %0d", want.col, center_col);
                        errs++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
            points_due <= pending_points.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import lfps_pkg::*;

    localparam int LATENCY      = 2;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 750;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic [COEFF_W-1:0]         C_MAX = COEFF_RST;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [IDX_W-1:0]           cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       sample_valid;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       result_valid;
    logic                       result_ready;
    logic signed [RESULT_W-1:0] result;
    logic [POS_W-1:0]           center_row;
    logic [POS_W-1:0]           center_col;
    logic                       last;

    int fail_count;
    int points_due;
    bit calm;
    bit hold_req;
    int cur_rows;
    int cur_cols;

    laplacian_five_point_stencil dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .center_row   (center_row),
        .center_col   (center_col),
        .last         (last)
    );

    stencil_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .center_row   (center_row),
        .center_col   (center_col),
        .last         (last),
        .mismatches   (fail_count),
        .points_due   (points_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_gap();
        int p;
        if (calm)
        begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 65)
        begin
            return 0;
        end
        if (p < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int p;
        int v;
        p = $urandom_range(0, 99);
        if (p < 60)
        begin
            return $urandom;
        end
        if (p < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        v = $urandom_range(0, 131072);
        return v - 65536;
    endfunction

    function automatic int clamp_dim(input int v);
        if (v < MIN_SIZE)
        begin
            return MIN_SIZE;
        end
        if (v > MAX_ROWS_DEF)
        begin
            return MAX_ROWS_DEF;
        end
        return v;
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff(input int eff);
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return COEFF_W'((eff - 1) * (eff - 1));
        end
        if (p < 75)
        begin
            return COEFF_W'($urandom_range(0, 1046529));
        end
        if (p < 87)
        begin
            return '0;
        end
        return C_MAX;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_size(input cfg_reg_t idx, input int v);
        logic [CFG_W-SIZE_W-1:0] spare_bits;
        spare_bits = (CFG_W-SIZE_W)'($urandom);
        if ($urandom_range(0, 9) >= 3)
        begin
            spare_bits = '0;
        end
        write_reg(idx, {spare_bits, v[SIZE_W-1:0]});
        if (idx == REG_ROWS)
        begin
            cur_rows = v;
        end
        else
        begin
            cur_cols = v;
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        sample_valid <= 1'b1;
        sample <= v;
        @(posedge clk);
        while (!sample_ready)
        begin
            @(posedge clk);
        end
        gap = idle_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_samples(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_sample(rand_sample());
        end
    endtask

    // 3x3 grid: one interior point with its four neighbors at the opposite extreme
    task automatic send_star(input logic signed [SAMPLE_W-1:0] centre,
                             input logic signed [SAMPLE_W-1:0] rim);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
            begin
                send_sample(centre);
            end
            else if (i % 2 == 1)
            begin
                send_sample(rim);
            end
            else
            begin
                send_sample(rand_sample());
            end
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (points_due != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin : receiver
        int hold_left;
        int stall_left;
        int g;
        result_ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                g = idle_gap();
                if (g == 0)
                begin
                    result_ready <= 1'b1;
                end
                else
                begin
                    result_ready <= 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("** laplacian_five_point_stencil: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int  random_sent;
        int  big_phases;
        int  rw;
        int  cw;
        int  grid;
        int  count;
        int  p;
        bit  big_grid;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        cur_rows = SIZE_RST;
        cur_cols = SIZE_RST;
        random_sent = 0;
        big_phases = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_size(REG_ROWS, 3);
        write_size(REG_COLS, 3);
        write_reg(REG_COEFFV, C_MAX);
        write_reg(REG_COEFFH, C_MAX);
        send_star(S_MIN, S_MAX);
        drain();
        write_size(REG_ROWS, 1);
        write_size(REG_COLS, 0);
        send_star(S_MAX, S_MIN);
        drain();

        // fill both rows of the line store; the output is held off while the fill starts
        write_size(REG_ROWS, 2);
        write_size(REG_COLS, 1024);
        write_reg(REG_COEFFV, pick_coeff(3));
        write_reg(REG_COEFFH, pick_coeff(1024));
        calm = 1'b1;
        hold_req = 1'b1;
        send_samples(3 * 1024);
        drain();
        calm = 1'b0;
        write_size(REG_ROWS, 1024);
        write_size(REG_COLS, 3);
        write_reg(REG_COEFFV, pick_coeff(1024));
        write_reg(REG_COEFFH, pick_coeff(3));
        send_samples(3 * 1024);
        drain();

        while (random_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            big_grid = 1'b0;
            p = $urandom_range(0, 99);
            if (p < 8)
            begin
                rw = $urandom_range(0, 2);
                cw = $urandom_range(0, 12);
            end
            else if (p < 12 && big_phases < 2)
            begin
                rw = $urandom_range(3, 4);
                cw = $urandom_range(1024, 2047);
                big_grid = 1'b1;
            end
            else if (p < 15 && big_phases < 2)
            begin
                rw = $urandom_range(1024, 2047);
                cw = $urandom_range(3, 5);
                big_grid = 1'b1;
            end
            else
            begin
                rw = $urandom_range(3, 8);
                cw = $urandom_range(3, 12);
            end
            if (big_grid || clamp_dim(cur_rows) > 12 || $urandom_range(0, 4) != 0)
            begin
                write_size(REG_ROWS, rw);
            end
            if (big_grid || clamp_dim(cur_cols) > 12 || $urandom_range(0, 4) != 0)
            begin
                write_size(REG_COLS, cw);
            end
            if ($urandom_range(0, 4) != 0)
            begin
                write_reg(REG_COEFFV, pick_coeff(clamp_dim(cur_rows)));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                write_reg(REG_COEFFH, pick_coeff(clamp_dim(cur_cols)));
            end
            grid = clamp_dim(cur_rows) * clamp_dim(cur_cols);
            if (big_grid)
            begin
                count = $urandom_range(1100, 2300);
                big_phases++;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                count = $urandom_range(1, 2 * grid);
            end
            else
            begin
                count = grid * $urandom_range(1, 4);
            end
            send_samples(count);
            if (!big_grid)
            begin
                random_sent += count;
            end
            drain();
        end

        calm = 1'b0;
        repeat (LATENCY * 4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** laplacian_five_point_stencil: PASSED **");
        end
        else
        begin
            $display("** laplacian_five_point_stencil: FAILED **");
        end
        $finish;
    end

endmodule
